@@ design/pipn_pkg.sv @@
// pipn_pkg: shared constants, register codes and pipeline word types
// for the point-in-primitive block; used by every module of the design
package pipn_pkg;

    localparam int COORD_W    = 32;
    localparam int EXT_W      = 31;
    localparam int NORM_W     = 16;
    localparam int NORM_FRAC  = 14;
    localparam int APB_DW     = 32;
    localparam int ADDR_W     = 5;
    localparam int SQ_W       = 2 * COORD_W;
    localparam int ROOT_W     = COORD_W;
    localparam int SQ_STEPS   = ROOT_W;
    localparam int QUO_W      = NORM_FRAC + 1;
    localparam int DIV_STEPS  = QUO_W;
    localparam int NUM_W      = COORD_W + QUO_W + 1;
    localparam int PROD_W     = COORD_W + NORM_W;
    localparam int DOT_W      = PROD_W + 2;
    localparam int BD_W       = COORD_W + 2;
    localparam int FIFO_DEPTH = 2;
    localparam int LANES      = 3;

    localparam logic signed [NORM_W-1:0] NORM_ONE = NORM_W'(1 << NORM_FRAC);

    typedef enum logic [1:0] {
        SHAPE_HALF,
        SHAPE_SPHERE,
        SHAPE_BOX,
        SHAPE_CYL
    } t_shape;

    typedef enum logic [2:0] {
        REG_SHAPE_KIND,
        REG_RADIUS,
        REG_HALF_X,
        REG_HALF_Y,
        REG_HALF_Z,
        REG_PLANE_NX,
        REG_PLANE_NY,
        REG_PLANE_NZ
    } t_reg_idx;

    typedef struct packed {
        t_shape                    kind;
        logic [EXT_W-1:0]          radius;
        logic [EXT_W-1:0]          half_x;
        logic [EXT_W-1:0]          half_y;
        logic [EXT_W-1:0]          half_z;
        logic signed [NORM_W-1:0]  plane_nx;
        logic signed [NORM_W-1:0]  plane_ny;
        logic signed [NORM_W-1:0]  plane_nz;
    } t_cfg;

    // classified word handed from front to back
    typedef struct packed {
        logic                             hit;
        logic                             use_div;
        logic [LANES-1:0][NORM_W-1:0]     nrm;
        logic [SQ_W-1:0]                  sum_sq;
        logic [LANES-1:0][COORD_W-1:0]    mag;
        logic [LANES-1:0]                 neg;
    } t_item;

endpackage

@@ design/pipn_front.sv @@
// pipn_front: two-stage front end; squares, dot-product terms and box face in
// stage one, containment test and normal selection in stage two (pipn_pkg)
module pipn_front (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  pipn_pkg::t_cfg                        i_cfg,
    input  logic                                  i_valid,
    output logic                                  o_ready,
    input  logic signed [pipn_pkg::COORD_W-1:0]   i_pos_x,
    input  logic signed [pipn_pkg::COORD_W-1:0]   i_pos_y,
    input  logic signed [pipn_pkg::COORD_W-1:0]   i_pos_z,
    output logic                                  o_valid,
    input  logic                                  i_ready,
    output pipn_pkg::t_item                       o_item
);
    import pipn_pkg::*;

    logic                       en;
    logic [COORD_W-1:0]         w_mx, w_my, w_mz;
    logic signed [BD_W-1:0]     w_dist [6];
    logic signed [BD_W-1:0]     w_best;
    logic [2:0]                 w_face;
    logic signed [BD_W-1:0]     w_a;
    logic                       w_apos;
    logic [COORD_W-1:0]         w_amag;

    logic                       r1_vld;
    logic [COORD_W-1:0]         r1_mx, r1_my, r1_mz;
    logic [LANES-1:0]           r1_neg;
    logic [SQ_W-1:0]            r1_sqx, r1_sqy, r1_sqz, r1_rr, r1_asq;
    logic                       r1_apos;
    logic signed [PROD_W-1:0]   r1_tx, r1_ty, r1_tz;
    logic                       r1_box_in;
    logic [2:0]                 r1_face;

    logic [SQ_W-1:0]            w_s3, w_s2;
    logic signed [DOT_W-1:0]    w_dot;
    t_item                      w_item;
    logic                       r_vld;
    t_item                      r_item;

    assign en      = !r_vld || i_ready;
    assign o_ready = en;
    assign o_valid = r_vld;
    assign o_item  = r_item;

    assign w_mx = i_pos_x[COORD_W-1] ? COORD_W'(-i_pos_x) : COORD_W'(i_pos_x);
    assign w_my = i_pos_y[COORD_W-1] ? COORD_W'(-i_pos_y) : COORD_W'(i_pos_y);
    assign w_mz = i_pos_z[COORD_W-1] ? COORD_W'(-i_pos_z) : COORD_W'(i_pos_z);

    // face distances in order left, right, front, back, bottom, top
    assign w_dist[0] = BD_W'(i_pos_x) + $signed(BD_W'(i_cfg.half_x));
    assign w_dist[1] = $signed(BD_W'(i_cfg.half_x)) - BD_W'(i_pos_x);
    assign w_dist[2] = BD_W'(i_pos_y) + $signed(BD_W'(i_cfg.half_y));
    assign w_dist[3] = $signed(BD_W'(i_cfg.half_y)) - BD_W'(i_pos_y);
    assign w_dist[4] = BD_W'(i_pos_z) + $signed(BD_W'(i_cfg.half_z));
    assign w_dist[5] = $signed(BD_W'(i_cfg.half_z)) - BD_W'(i_pos_z);

    always_comb begin
        w_best = w_dist[0];
        w_face = '0;
        for (int f = 1; f < 6; f++) begin
            if (w_dist[f] < w_best) begin
                w_best = w_dist[f];
                w_face = 3'(f);
            end
        end
    end

    // cylinder: radius - (half_z - |z|), radial wins when this squared <= r_xy^2
    assign w_a    = $signed(BD_W'(i_cfg.radius)) - $signed(BD_W'(i_cfg.half_z))
                    + $signed(BD_W'(w_mz));
    assign w_apos = (w_a > 0);
    assign w_amag = w_apos ? w_a[COORD_W-1:0] : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_vld <= 1'b0;
            r_vld  <= 1'b0;
        end else if (en) begin
            r1_vld <= i_valid;
            r_vld  <= r1_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r1_mx     <= w_mx;
            r1_my     <= w_my;
            r1_mz     <= w_mz;
            r1_neg    <= {i_pos_z[COORD_W-1], i_pos_y[COORD_W-1], i_pos_x[COORD_W-1]};
            r1_sqx    <= SQ_W'(w_mx) * SQ_W'(w_mx);
            r1_sqy    <= SQ_W'(w_my) * SQ_W'(w_my);
            r1_sqz    <= SQ_W'(w_mz) * SQ_W'(w_mz);
            r1_rr     <= SQ_W'(i_cfg.radius) * SQ_W'(i_cfg.radius);
            r1_asq    <= SQ_W'(w_amag) * SQ_W'(w_amag);
            r1_apos   <= w_apos;
            r1_tx     <= PROD_W'(i_pos_x) * PROD_W'(i_cfg.plane_nx);
            r1_ty     <= PROD_W'(i_pos_y) * PROD_W'(i_cfg.plane_ny);
            r1_tz     <= PROD_W'(i_pos_z) * PROD_W'(i_cfg.plane_nz);
            r1_box_in <= (w_mx <= COORD_W'(i_cfg.half_x)) && (w_my <= COORD_W'(i_cfg.half_y))
                         && (w_mz <= COORD_W'(i_cfg.half_z));
            r1_face   <= w_face;
            r_item    <= w_item;
        end
    end

    assign w_s2  = r1_sqx + r1_sqy;
    assign w_s3  = w_s2 + r1_sqz;
    assign w_dot = DOT_W'(r1_tx) + DOT_W'(r1_ty) + DOT_W'(r1_tz);

    always_comb begin
        w_item         = '0;
        w_item.mag     = {r1_mz, r1_my, r1_mx};
        w_item.neg     = r1_neg;
        w_item.sum_sq  = w_s3;
        unique case (i_cfg.kind)
            SHAPE_HALF: begin
                w_item.hit = (w_dot <= 0);
                if (w_item.hit) begin
                    w_item.nrm = {i_cfg.plane_nz, i_cfg.plane_ny, i_cfg.plane_nx};
                end
            end
            SHAPE_SPHERE: begin
                w_item.hit = (w_s3 <= r1_rr);
                if (w_item.hit) begin
                    if (w_s3 == '0) begin
                        w_item.nrm[0] = NORM_ONE;
                    end else begin
                        w_item.use_div = 1'b1;
                    end
                end
            end
            SHAPE_BOX: begin
                w_item.hit = r1_box_in;
                if (w_item.hit) begin
                    w_item.nrm[r1_face[2:1]] = r1_face[0] ? NORM_ONE : -NORM_ONE;
                end
            end
            SHAPE_CYL: begin
                w_item.sum_sq = w_s2;
                w_item.hit = (w_s2 <= r1_rr) && (r1_mz <= COORD_W'(i_cfg.half_z));
                if (w_item.hit) begin
                    if (!r1_apos || (r1_asq <= w_s2)) begin
                        // radial; on the axis the normal stays zero
                        if (w_s2 != '0) begin
                            w_item.use_div = 1'b1;
                            w_item.mag[2]  = '0;
                        end
                    end else begin
                        w_item.nrm[2] = r1_neg[2] ? -NORM_ONE : NORM_ONE;
                    end
                end
            end
            default: w_item.hit = 1'b0;
        endcase
    end

endmodule

@@ design/pipn_fifo.sv @@
// pipn_fifo: short queue of classified words between front and back end
// depends on pipn_pkg for the word type and depth
module pipn_fifo (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  pipn_pkg::t_item  i_data,
    output logic             o_full,
    output logic             o_valid,
    input  logic             i_pop,
    output pipn_pkg::t_item  o_data
);
    import pipn_pkg::*;

    localparam int PTR_W = $clog2(FIFO_DEPTH);

    t_item              r_mem [FIFO_DEPTH];
    logic [PTR_W-1:0]   r_wp, r_rp;
    logic [PTR_W:0]     r_cnt;
    logic               do_push, do_pop;

    assign o_full  = (r_cnt == (PTR_W+1)'(FIFO_DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_data  = r_mem[r_rp];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) r_wp <= r_wp + 1'b1;
            if (do_pop)  r_rp <= r_rp + 1'b1;
            r_cnt <= r_cnt + (PTR_W+1)'(do_push) - (PTR_W+1)'(do_pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) r_mem[r_wp] <= i_data;
    end

endmodule

@@ design/pipn_back.sv @@
// pipn_back: pipelined square root (one bit per stage), then three-lane
// pipelined divider for the unit normal, then output register (pipn_pkg)
module pipn_back (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_valid,
    output logic                                 o_pop,
    input  pipn_pkg::t_item                      i_item,
    output logic                                 o_valid,
    input  logic                                 i_ready,
    output logic                                 o_inside_res,
    output logic signed [pipn_pkg::NORM_W-1:0]   o_norm_x,
    output logic signed [pipn_pkg::NORM_W-1:0]   o_norm_y,
    output logic signed [pipn_pkg::NORM_W-1:0]   o_norm_z
);
    import pipn_pkg::*;

    logic                    en;
    logic                    r_sq_vld  [SQ_STEPS];
    t_item                   r_sq_item [SQ_STEPS];
    logic [SQ_W-1:0]         r_sq_rem  [SQ_STEPS];
    logic [ROOT_W-1:0]       r_sq_root [SQ_STEPS];

    logic                              r_dv_vld  [DIV_STEPS];
    t_item                             r_dv_item [DIV_STEPS];
    logic [ROOT_W-1:0]                 r_dv_len  [DIV_STEPS];
    logic [LANES-1:0][NUM_W-1:0]       r_dv_rem  [DIV_STEPS];
    logic [LANES-1:0][QUO_W-1:0]       r_dv_q    [DIV_STEPS];

    logic                              r_out_vld;
    logic                              r_out_inside;
    logic [LANES-1:0][NORM_W-1:0]      r_out_nrm;
    logic [LANES-1:0][NORM_W-1:0]      w_nrm;
    t_item                             w_last;

    assign en           = !r_out_vld || i_ready;
    assign o_pop        = en && i_valid;
    assign o_valid      = r_out_vld;
    assign o_inside_res = r_out_inside;
    assign o_norm_x     = $signed(r_out_nrm[0]);
    assign o_norm_y     = $signed(r_out_nrm[1]);
    assign o_norm_z     = $signed(r_out_nrm[2]);

    // square root: remainder tracks sum_sq - root^2
    for (genvar k = 0; k < SQ_STEPS; k++) begin : g_sq
        localparam int B = SQ_STEPS - 1 - k;
        logic              v_in;
        t_item             it_in;
        logic [SQ_W-1:0]   rem_in, trial;
        logic [ROOT_W-1:0] root_in;

        if (k == 0) begin : g_first
            assign v_in    = i_valid;
            assign it_in   = i_item;
            assign rem_in  = i_item.sum_sq;
            assign root_in = '0;
        end else begin : g_next
            assign v_in    = r_sq_vld[k-1];
            assign it_in   = r_sq_item[k-1];
            assign rem_in  = r_sq_rem[k-1];
            assign root_in = r_sq_root[k-1];
        end

        assign trial = (SQ_W'(root_in) << (B + 1)) | (SQ_W'(1) << (2 * B));

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_sq_vld[k] <= 1'b0;
            end else if (en) begin
                r_sq_vld[k] <= v_in;
            end
        end

        always_ff @(posedge i_clk) begin
            if (en) begin
                r_sq_item[k] <= it_in;
                if (rem_in >= trial) begin
                    r_sq_rem[k]  <= rem_in - trial;
                    r_sq_root[k] <= root_in | (ROOT_W'(1) << B);
                end else begin
                    r_sq_rem[k]  <= rem_in;
                    r_sq_root[k] <= root_in;
                end
            end
        end
    end

    // restoring divide: (|p| * 2^(F+1) + len) / (2 * len), quotient below 2^(F+1)
    for (genvar j = 0; j < DIV_STEPS; j++) begin : g_dv
        localparam int I = DIV_STEPS - 1 - j;
        logic                          v_in;
        t_item                         it_in;
        logic [ROOT_W-1:0]             len_in;
        logic [LANES-1:0][NUM_W-1:0]   rem_in;
        logic [LANES-1:0][QUO_W-1:0]   q_in;
        logic [NUM_W-1:0]              dsh;

        if (j == 0) begin : g_first
            assign v_in   = r_sq_vld[SQ_STEPS-1];
            assign it_in  = r_sq_item[SQ_STEPS-1];
            assign len_in = r_sq_root[SQ_STEPS-1];
            always_comb begin
                for (int l = 0; l < LANES; l++) begin
                    rem_in[l] = (NUM_W'(it_in.mag[l]) << QUO_W) + NUM_W'(len_in);
                end
            end
            assign q_in = '0;
        end else begin : g_next
            assign v_in   = r_dv_vld[j-1];
            assign it_in  = r_dv_item[j-1];
            assign len_in = r_dv_len[j-1];
            assign rem_in = r_dv_rem[j-1];
            assign q_in   = r_dv_q[j-1];
        end

        assign dsh = NUM_W'({len_in, 1'b0}) << I;

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_dv_vld[j] <= 1'b0;
            end else if (en) begin
                r_dv_vld[j] <= v_in;
            end
        end

        always_ff @(posedge i_clk) begin
            if (en) begin
                r_dv_item[j] <= it_in;
                r_dv_len[j]  <= len_in;
                for (int l = 0; l < LANES; l++) begin
                    if (rem_in[l] >= dsh) begin
                        r_dv_rem[j][l] <= rem_in[l] - dsh;
                        r_dv_q[j][l]   <= q_in[l] | (QUO_W'(1) << I);
                    end else begin
                        r_dv_rem[j][l] <= rem_in[l];
                        r_dv_q[j][l]   <= q_in[l];
                    end
                end
            end
        end
    end

    assign w_last = r_dv_item[DIV_STEPS-1];

    always_comb begin
        for (int l = 0; l < LANES; l++) begin
            if (w_last.use_div) begin
                w_nrm[l] = w_last.neg[l] ? -NORM_W'(r_dv_q[DIV_STEPS-1][l])
                                         :  NORM_W'(r_dv_q[DIV_STEPS-1][l]);
            end else begin
                w_nrm[l] = w_last.nrm[l];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (en) begin
            r_out_vld <= r_dv_vld[DIV_STEPS-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_out_inside <= w_last.hit;
            r_out_nrm    <= w_nrm;
        end
    end

endmodule

@@ design/point_in_primitive_with_normal_core.sv @@
// Point-in-shape test with outward normal.
// Input channel i_in_valid / o_in_ready carries one point word (i_pos_x/y/z,
// signed Q16.16). Output channel o_out_valid / i_out_ready carries one result
// word per point: o_inside_res and the outward unit normal o_norm_x/y/z in
// Q1.14 (all zero for an outside point).
// Shape and extents are set through the APB port (psel ... pready), registers
// at byte addresses 4*i; pready is always high. Write them only while idle.
// From acceptance to o_out_valid a word passes two front stages, the queue,
// 32 square-root stages (one root bit each), 15 divider stages (one quotient
// bit each) and the output register. Throughput is one word per cycle while
// i_out_ready stays high: the root and divide units are fully pipelined and
// every shape takes the same path.
// When the receiver holds i_out_ready low the back pipeline freezes with the
// result held; the front keeps accepting until the two-entry queue and its own
// two stages fill.
// Reset (synchronous, active low) empties every stage and the queue and loads
// the register reset values: half-space with normal +z, extents and radius 1.0.
// Depends on pipn_pkg, pipn_front, pipn_fifo, pipn_back.
module point_in_primitive_with_normal_core (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 psel,
    input  logic                                 penable,
    input  logic                                 pwrite,
    input  logic [pipn_pkg::ADDR_W-1:0]          paddr,
    input  logic [pipn_pkg::APB_DW-1:0]          pwdata,
    output logic [pipn_pkg::APB_DW-1:0]          prdata,
    output logic                                 pready,
    input  logic                                 i_in_valid,
    output logic                                 o_in_ready,
    input  logic signed [pipn_pkg::COORD_W-1:0]  i_pos_x,
    input  logic signed [pipn_pkg::COORD_W-1:0]  i_pos_y,
    input  logic signed [pipn_pkg::COORD_W-1:0]  i_pos_z,
    output logic                                 o_out_valid,
    input  logic                                 i_out_ready,
    output logic                                 o_inside_res,
    output logic signed [pipn_pkg::NORM_W-1:0]   o_norm_x,
    output logic signed [pipn_pkg::NORM_W-1:0]   o_norm_y,
    output logic signed [pipn_pkg::NORM_W-1:0]   o_norm_z
);
    import pipn_pkg::*;

    t_cfg       r_cfg;
    t_reg_idx   w_idx;
    logic       fr_valid, q_full, q_valid, q_pop;
    t_item      fr_item, q_item;

    assign pready = 1'b1;
    assign w_idx  = t_reg_idx'(paddr[ADDR_W-1:2]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.kind     <= SHAPE_HALF;
            r_cfg.radius   <= EXT_W'(1 << 16);
            r_cfg.half_x   <= EXT_W'(1 << 16);
            r_cfg.half_y   <= EXT_W'(1 << 16);
            r_cfg.half_z   <= EXT_W'(1 << 16);
            r_cfg.plane_nx <= '0;
            r_cfg.plane_ny <= '0;
            r_cfg.plane_nz <= NORM_ONE;
        end else if (psel && penable && pwrite) begin
            unique case (w_idx)
                REG_SHAPE_KIND: r_cfg.kind     <= t_shape'(pwdata[1:0]);
                REG_RADIUS:     r_cfg.radius   <= pwdata[EXT_W-1:0];
                REG_HALF_X:     r_cfg.half_x   <= pwdata[EXT_W-1:0];
                REG_HALF_Y:     r_cfg.half_y   <= pwdata[EXT_W-1:0];
                REG_HALF_Z:     r_cfg.half_z   <= pwdata[EXT_W-1:0];
                REG_PLANE_NX:   r_cfg.plane_nx <= pwdata[NORM_W-1:0];
                REG_PLANE_NY:   r_cfg.plane_ny <= pwdata[NORM_W-1:0];
                REG_PLANE_NZ:   r_cfg.plane_nz <= pwdata[NORM_W-1:0];
                default:        r_cfg.kind     <= r_cfg.kind;
            endcase
        end
    end

    always_comb begin
        unique case (w_idx)
            REG_SHAPE_KIND: prdata = APB_DW'(r_cfg.kind);
            REG_RADIUS:     prdata = APB_DW'(r_cfg.radius);
            REG_HALF_X:     prdata = APB_DW'(r_cfg.half_x);
            REG_HALF_Y:     prdata = APB_DW'(r_cfg.half_y);
            REG_HALF_Z:     prdata = APB_DW'(r_cfg.half_z);
            REG_PLANE_NX:   prdata = APB_DW'(unsigned'(r_cfg.plane_nx));
            REG_PLANE_NY:   prdata = APB_DW'(unsigned'(r_cfg.plane_ny));
            REG_PLANE_NZ:   prdata = APB_DW'(unsigned'(r_cfg.plane_nz));
            default:        prdata = '0;
        endcase
    end

    pipn_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (r_cfg),
        .i_valid (i_in_valid),
        .o_ready (o_in_ready),
        .i_pos_x (i_pos_x),
        .i_pos_y (i_pos_y),
        .i_pos_z (i_pos_z),
        .o_valid (fr_valid),
        .i_ready (!q_full),
        .o_item  (fr_item)
    );

    pipn_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (fr_valid),
        .i_data  (fr_item),
        .o_full  (q_full),
        .o_valid (q_valid),
        .i_pop   (q_pop),
        .o_data  (q_item)
    );

    pipn_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (q_valid),
        .o_pop        (q_pop),
        .i_item       (q_item),
        .o_valid      (o_out_valid),
        .i_ready      (i_out_ready),
        .o_inside_res (o_inside_res),
        .o_norm_x     (o_norm_x),
        .o_norm_y     (o_norm_y),
        .o_norm_z     (o_norm_z)
    );

endmodule

@@ design/pipn_chk.sv @@
// pipn_chk: port-level checks on the point-in-primitive core, bound to it
// depends on pipn_pkg for the field widths
module pipn_chk (
    input logic                                 i_clk,
    input logic                                 i_rst_n,
    input logic                                 o_out_valid,
    input logic                                 i_out_ready,
    input logic                                 o_inside_res,
    input logic signed [pipn_pkg::NORM_W-1:0]   o_norm_x,
    input logic signed [pipn_pkg::NORM_W-1:0]   o_norm_y,
    input logic signed [pipn_pkg::NORM_W-1:0]   o_norm_z
);
    import pipn_pkg::*;

    // a stalled result word holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_inside_res)
        && $stable(o_norm_x) && $stable(o_norm_y) && $stable(o_norm_z))
        else $error("result word changed under stall");

    a_outside_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_inside_res |-> o_norm_x == '0 && o_norm_y == '0
        && o_norm_z == '0)
        else $error("outside point with nonzero normal");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid right after reset");

endmodule

bind point_in_primitive_with_normal_core pipn_chk u_chk (.*);
